FILE: hdl/assert_macros.svh
// assertion macros shared by the filter rtl
// expands to concurrent assertions in simulation and to nothing in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SNN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("snn assertion failed");
// condition must never be seen outside reset
`define SNN_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("snn forbidden condition seen");
`else
`define SNN_ASSERT(lbl, prop)
`define SNN_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hdl/snn_pkg.sv
// shared types and constants of the symmetric nearest neighbour filter
// used by the channel interfaces and the core; depends on nothing
package snn_pkg;

  // width of one colour channel on the ports
  localparam int unsigned PIX_W = 16;
  // width of the configuration write data
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS,
    CFG_PAIRS,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_idx_e;

  // register values after reset
  localparam logic [3:0]  RADIUS_RST = 4'd8;
  localparam logic [1:0]  PAIRS_RST  = 2'd2;
  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [15:0] HEIGHT_RST = 16'd1024;

  // pairs value that selects symmetric pairs, anything else means quadruples
  localparam logic [1:0] PAIRS_MODE = 2'd1;

endpackage

FILE: hdl/snn_if.sv
// valid/ready channel interfaces of the filter: pixel in, result out, config
// depends on snn_pkg
interface snn_pix_if;
  logic          valid;
  logic          ready;
  snn_pkg::pix_t in_red;
  snn_pkg::pix_t in_green;
  snn_pkg::pix_t in_blue;
  snn_pkg::pix_t in_alpha;
  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface snn_res_if;
  logic          valid;
  logic          ready;
  snn_pkg::pix_t out_red;
  snn_pkg::pix_t out_green;
  snn_pkg::pix_t out_blue;
  snn_pkg::pix_t out_alpha;
  logic          frame_end;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                output ready);
endinterface

interface snn_cfg_if;
  logic                valid;
  logic                ready;
  snn_pkg::cfg_idx_e   index;
  snn_pkg::cfg_data_t  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/symmetric_nearest_neighbour_mean_core.sv
// Symmetric nearest neighbour mean filter, one item in at a time.
// An item that completes a window starts a job: the centre and the members of each window
// position besides the centre (2 or 4 each) are read from the row store, the nearest member
// of each is summed, and the rounded sums are divided by the sample count. The next item is
// taken once the result is loaded into the result register; other items do not hold the input.
// Reset clears counters and control and loads the register defaults; the row store is kept.
`include "assert_macros.svh"

module symmetric_nearest_neighbour_mean_core #(
  parameter int unsigned MAX_RADIUS   = 8,
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  snn_pix_if.sink    pix_i,
  snn_res_if.source  res_o,
  snn_cfg_if.sink    cfg_i
);

  localparam int unsigned CB      = CHANNEL_BITS;
  localparam int unsigned PW      = 4 * CB;
  localparam int unsigned ROWS    = 2 * MAX_RADIUS + 1;
  localparam int unsigned SLOT_W  = $clog2(ROWS);
  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned COLW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW      = SLOT_W + CW;
  localparam int unsigned DEPTH   = ROWS * (2 ** CW);
  localparam int unsigned RW      = $clog2(MAX_RADIUS + 1);
  localparam int unsigned XW      = ((CW > RW) ? CW : RW) + 2;
  localparam int unsigned CNT_MAX = 2 * MAX_RADIUS * (MAX_RADIUS + 1) + 1;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);
  localparam int unsigned ACC_W   = CB + CNT_W;
  localparam int unsigned SQ_W    = 2 * CB;
  localparam int unsigned DW      = SQ_W + 2;
  localparam int unsigned ITW     = $clog2(ACC_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTRE,
    S_ISSUE,
    S_WAIT,
    S_DIVLD,
    S_DIV,
    S_PUT
  } state_e;

  typedef struct packed {
    logic first;
    logic last;
    logic fin;
    logic centre;
  } tag_t;

  // configuration registers
  logic [3:0]  radius_q;
  logic [1:0]  pairs_q;
  logic [10:0] fwidth_q;
  logic [15:0] fheight_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= snn_pkg::RADIUS_RST;
      pairs_q   <= snn_pkg::PAIRS_RST;
      fwidth_q  <= snn_pkg::WIDTH_RST;
      fheight_q <= snn_pkg::HEIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        snn_pkg::CFG_RADIUS: radius_q  <= cfg_i.data[3:0];
        snn_pkg::CFG_PAIRS:  pairs_q   <= cfg_i.data[1:0];
        snn_pkg::CFG_WIDTH:  fwidth_q  <= cfg_i.data[10:0];
        snn_pkg::CFG_HEIGHT: fheight_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // effective radius, width and height
  logic [RW-1:0]   r_eff;
  logic [COLW-1:0] w_eff;
  logic [15:0]     h_eff;

  always_comb begin
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
    if (fwidth_q == '0) begin
      w_eff = COLW'(1);
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      w_eff = COLW'(MAX_WIDTH);
    end else begin
      w_eff = COLW'(fwidth_q);
    end
    h_eff = (fheight_q == '0) ? 16'd1 : fheight_q;
  end

  // raster position of the arriving item
  logic [CW-1:0]     col_q;
  logic [15:0]       row_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CW-1:0]     cur_col;
  logic [15:0]       cur_row;
  logic [SLOT_W-1:0] cur_slot;
  logic              produce;
  logic              last_px;
  logic              col_wrap;
  logic              row_wrap;

  always_comb begin
    cur_col  = (32'(col_q) >= 32'(w_eff)) ? '0 : col_q;
    cur_row  = (row_q >= h_eff) ? '0 : row_q;
    cur_slot = (row_q >= h_eff) ? '0 : slot_q;
    produce  = (32'(cur_col) >= (32'(r_eff) << 1)) && (32'(cur_row) >= (32'(r_eff) << 1));
    col_wrap = (32'(cur_col) + 32'd1) >= 32'(w_eff);
    row_wrap = (32'(cur_row) + 32'd1) >= 32'(h_eff);
    last_px  = col_wrap && row_wrap;
  end

  logic accept;
  assign accept = pix_i.valid && pix_i.ready;

  // job and sequencer registers
  state_e            state_q;
  logic [CW-1:0]     cx_q;
  logic [SLOT_W-1:0] rs_q;
  logic [RW-1:0]     rad_q;
  logic              quad_q;
  logic              fend_q;
  logic signed [RW:0] u_q;
  logic signed [RW:0] v_q;
  logic [1:0]        m_q;

  // next window position and end of sweep
  logic signed [RW:0] ulim;
  logic signed [RW:0] u_nx;
  logic signed [RW:0] v_nx;
  logic [1:0]         m_last;
  logic               sweep_end;

  always_comb begin
    ulim   = quad_q ? '0 : $signed({1'b0, rad_q});
    m_last = quad_q ? 2'd3 : 2'd1;
    if (u_q == ulim) begin
      u_nx = -$signed({1'b0, rad_q});
      v_nx = v_q + $signed((RW+1)'(1));
    end else begin
      u_nx = u_q + $signed((RW+1)'(1));
      v_nx = v_q;
    end
    sweep_end = (u_nx == '0) && (v_nx == '0);
  end

  // member address: column cx +/- u, row offset back from the newest row
  logic               centre_iss;
  logic signed [RW:0] u_use;
  logic signed [RW:0] v_use;
  logic signed [RW:0] du;
  logic signed [RW+1:0] kr;
  logic signed [XW-1:0] col_s;
  logic signed [SLOT_W+1:0] sd;
  logic [SLOT_W-1:0] rd_slot;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  tag_t              iss_tag;

  always_comb begin
    centre_iss = (state_q == S_CENTRE);
    u_use = centre_iss ? '0 : u_q;
    v_use = centre_iss ? '0 : v_q;
    du = ((m_q == 2'd0) || (m_q == 2'd3)) ? u_use : -u_use;
    if ((m_q == 2'd0) || (m_q == 2'd2)) begin
      kr = $signed({2'b00, rad_q}) - (RW+2)'(v_use);
    end else begin
      kr = $signed({2'b00, rad_q}) + (RW+2)'(v_use);
    end
    col_s   = $signed(XW'(cx_q)) + XW'(du);
    sd      = $signed({2'b00, rs_q}) - (SLOT_W+2)'(kr);
    rd_slot = (sd < 0) ? SLOT_W'(sd + $signed((SLOT_W+2)'(ROWS))) : SLOT_W'(sd);
    rd_addr = {rd_slot, col_s[CW-1:0]};
    rd_en   = (state_q == S_CENTRE) || (state_q == S_ISSUE);
    iss_tag.centre = centre_iss;
    iss_tag.first  = centre_iss || (m_q == 2'd0);
    iss_tag.last   = centre_iss || (m_q == m_last);
    iss_tag.fin    = centre_iss ? (rad_q == '0) : ((m_q == m_last) && sweep_end);
  end

  // row store: one write and one registered read per cycle
  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rdata_q;
  logic [PW-1:0] wdata;

  assign wdata = {CB'(pix_i.in_alpha), CB'(pix_i.in_blue),
                  CB'(pix_i.in_green), CB'(pix_i.in_red)};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[{cur_slot, cur_col}] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // pipeline valid and tags
  logic s1_v_q;
  tag_t s1_tag_q;
  logic s2_v_q;
  tag_t s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_tag_q <= '0;
      s2_v_q   <= 1'b0;
      s2_tag_q <= '0;
    end else begin
      s1_v_q   <= rd_en;
      s1_tag_q <= iss_tag;
      s2_v_q   <= s1_v_q;
      s2_tag_q <= s1_tag_q;
    end
  end

  // centre capture and squared channel differences
  logic [PW-1:0]   centre_q;
  logic [PW-1:0]   s2_pix_q;
  logic [SQ_W-1:0] sq_q [3];
  logic [CB-1:0]   diff [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (rdata_q[k*CB +: CB] > centre_q[k*CB +: CB]) ?
                rdata_q[k*CB +: CB] - centre_q[k*CB +: CB] :
                centre_q[k*CB +: CB] - rdata_q[k*CB +: CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s1_tag_q.centre) begin
      centre_q <= rdata_q;
    end
    s2_pix_q <= rdata_q;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= SQ_W'(diff[k]) * SQ_W'(diff[k]);
    end
  end

  // nearest member selection and accumulation
  logic [DW-1:0]    cand_dist;
  logic             better;
  logic [PW-1:0]    chosen;
  logic [DW-1:0]    best_q;
  logic [PW-1:0]    pick_q;
  logic [ACC_W-1:0] acc_q [4];
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] num_q [4];
  logic [CNT_W:0]   rem_q [4];
  logic [ITW-1:0]   it_q;
  logic [CNT_W:0]   trial [4];
  logic             take [4];

  always_comb begin
    cand_dist = DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);
    better    = s2_tag_q.first || (cand_dist < best_q);
    chosen    = better ? s2_pix_q : pick_q;
    for (int k = 0; k < 4; k++) begin
      trial[k] = {rem_q[k][CNT_W-1:0], num_q[k][ACC_W-1]};
      take[k]  = trial[k] >= (CNT_W+1)'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        acc_q[k] <= '0;
      end
      cnt_q <= '0;
    end else if (s2_v_q) begin
      if (better) begin
        best_q <= cand_dist;
        pick_q <= s2_pix_q;
      end
      if (s2_tag_q.last) begin
        for (int k = 0; k < 4; k++) begin
          acc_q[k] <= acc_q[k] + ACC_W'(chosen[k*CB +: CB]);
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
    // restoring division of the rounded sums by the sample count
    if (state_q == S_DIVLD) begin
      for (int k = 0; k < 4; k++) begin
        num_q[k] <= acc_q[k] + ACC_W'(cnt_q >> 1);
        rem_q[k] <= '0;
      end
    end else if (state_q == S_DIV) begin
      for (int k = 0; k < 4; k++) begin
        rem_q[k] <= take[k] ? trial[k] - (CNT_W+1)'(cnt_q) : trial[k];
        num_q[k] <= {num_q[k][ACC_W-2:0], take[k]};
      end
    end
  end

  // control sequencer and result register
  logic          res_valid_q;
  snn_pkg::pix_t res_q [4];
  logic          res_fend_q;

  assign pix_i.ready     = (state_q == S_IDLE);
  assign res_o.valid     = res_valid_q;
  assign res_o.out_red   = res_q[0];
  assign res_o.out_green = res_q[1];
  assign res_o.out_blue  = res_q[2];
  assign res_o.out_alpha = res_q[3];
  assign res_o.frame_end = res_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      res_valid_q <= 1'b0;
      it_q        <= '0;
      m_q         <= '0;
    end else begin
      // the result register is reloaded in S_PUT, drained elsewhere
      if (res_o.ready && (state_q != S_PUT)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            // advance the raster position
            if (col_wrap) begin
              col_q  <= '0;
              row_q  <= row_wrap ? '0 : cur_row + 16'd1;
              slot_q <= (row_wrap || (32'(cur_slot) == ROWS - 1)) ? '0 : cur_slot + 1'b1;
            end else begin
              col_q  <= cur_col + 1'b1;
              row_q  <= cur_row;
              slot_q <= cur_slot;
            end
            if (produce) begin
              state_q <= S_CENTRE;
              cx_q    <= cur_col - CW'(r_eff);
              rs_q    <= cur_slot;
              rad_q   <= r_eff;
              quad_q  <= (pairs_q != snn_pkg::PAIRS_MODE);
              fend_q  <= last_px;
              u_q     <= -$signed({1'b0, r_eff});
              v_q     <= -$signed({1'b0, r_eff});
              m_q     <= '0;
            end
          end
        end
        S_CENTRE: begin
          state_q <= (rad_q == '0) ? S_WAIT : S_ISSUE;
        end
        S_ISSUE: begin
          if (m_q == m_last) begin
            m_q <= '0;
            u_q <= u_nx;
            v_q <= v_nx;
            if (sweep_end) begin
              state_q <= S_WAIT;
            end
          end else begin
            m_q <= m_q + 2'd1;
          end
        end
        S_WAIT: begin
          if (s2_v_q && s2_tag_q.fin) begin
            state_q <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          it_q    <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          it_q <= it_q + 1'b1;
          if (32'(it_q) == ACC_W - 1) begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (!res_valid_q || res_o.ready) begin
            for (int k = 0; k < 4; k++) begin
              res_q[k] <= snn_pkg::PIX_W'(num_q[k][CB-1:0]);
            end
            res_fend_q  <= fend_q;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks on the sequencer and the datapath
  `SNN_ASSERT(a_fin_in_wait, (s2_v_q && s2_tag_q.fin) |-> (state_q == S_WAIT))
  `SNN_ASSERT(a_count_nonzero, (state_q == S_DIVLD) |-> (cnt_q != '0))
  `SNN_ASSERT(a_result_from_put, $rose(res_valid_q) |-> $past(state_q == S_PUT))
  `SNN_ASSERT_NEVER(a_read_while_idle, s1_v_q && (state_q == S_IDLE))

endmodule

FILE: test/tb_top.sv
// testbench of the symmetric nearest neighbour mean filter core
// streams whole frames through the pixel channel and checks every result
// depends on snn_pkg, the channel interfaces in snn_if.sv and the core
module tb_top;

  localparam int unsigned STORE_ROWS = 17;
  localparam int unsigned WIDTH_MAX  = 1024;
  localparam int unsigned IDLE_WAIT  = 420;

  typedef struct packed {
    snn_pkg::pix_t red;
    snn_pkg::pix_t green;
    snn_pkg::pix_t blue;
    snn_pkg::pix_t alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t pix;
    logic  frame_end;
  } filt_res_t;

  logic clk_i;
  logic rst_ni;

  snn_pix_if pix ();
  snn_res_if res ();
  snn_cfg_if cfg ();

  symmetric_nearest_neighbour_mean_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix.sink),
    .res_o  (res.source),
    .cfg_i  (cfg.sink)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // predictor copy of the registers and the row store
  logic [3:0]  radius_q;
  logic [1:0]  pairs_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  int unsigned col_cnt;
  int unsigned row_cnt;
  rgba_t       row_mem [STORE_ROWS][WIDTH_MAX];

  rgba_t       pending_pix [$];
  filt_res_t   expected_res [$];
  int          errors = 0;
  bit          in_fired;
  int          in_gap;
  int          out_gap;
  bit          no_gaps;
  bit          hold_req;
  bit          hold_done;
  int          hold_cnt;

  function automatic rgba_t sample_at(int col, int row);
    int unsigned c;
    c = (col >= WIDTH_MAX) ? WIDTH_MAX - 1 : col;
    return row_mem[row % STORE_ROWS][c];
  endfunction

  function automatic longint unsigned colour_dist(rgba_t a, rgba_t b);
    longint unsigned dr, dg, db;
    dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
    dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
    return dr * dr + dg * dg + db * db;
  endfunction

  // store one item and work out the filtered pixel it completes, if any
  function automatic bit filter_pixel(input rgba_t p, output filt_res_t r);
    int unsigned     rad, wd, ht, c, rw;
    int              cx, cy, ulim, members, u, v, i;
    longint unsigned acc_r, acc_g, acc_b, acc_a, cnt, best, d;
    int              xs [4];
    int              ys [4];
    rgba_t           centre, pick, t;
    bit              done, made;
    rad = (radius_q > 8) ? 8 : radius_q;
    wd  = (width_q == 0) ? 1 : ((width_q > WIDTH_MAX) ? WIDTH_MAX : width_q);
    ht  = (height_q == 0) ? 1 : height_q;
    if (col_cnt >= wd) col_cnt = 0;
    if (row_cnt >= ht) row_cnt = 0;
    c  = col_cnt;
    rw = row_cnt;
    row_mem[rw % STORE_ROWS][c] = p;
    made = 1'b0;
    r = '0;
    if (c >= 2 * rad && rw >= 2 * rad) begin
      cx = c - rad;
      cy = rw - rad;
      ulim = (pairs_q == snn_pkg::PAIRS_MODE) ? rad : 0;
      members = (pairs_q == snn_pkg::PAIRS_MODE) ? 2 : 4;
      centre = sample_at(cx, cy);
      acc_r = 0; acc_g = 0; acc_b = 0; acc_a = 0; cnt = 0;
      done = 1'b0;
      for (v = -int'(rad); v <= 0 && !done; v++) begin
        for (u = -int'(rad); u <= ulim; u++) begin
          if (u == 0 && v == 0) begin
            pick = centre;
          end else begin
            xs[0] = cx + u; ys[0] = cy + v;
            xs[1] = cx - u; ys[1] = cy - v;
            xs[2] = cx - u; ys[2] = cy + v;
            xs[3] = cx + u; ys[3] = cy - v;
            pick = sample_at(xs[0], ys[0]);
            best = colour_dist(pick, centre);
            for (i = 1; i < members; i++) begin
              t = sample_at(xs[i], ys[i]);
              d = colour_dist(t, centre);
              if (d < best) begin
                best = d;
                pick = t;
              end
            end
          end
          acc_r += pick.red;
          acc_g += pick.green;
          acc_b += pick.blue;
          acc_a += pick.alpha;
          cnt++;
          if (u == 0 && v == 0) begin
            done = 1'b1;
            break;
          end
        end
      end
      r.pix.red   = snn_pkg::pix_t'((acc_r + cnt / 2) / cnt);
      r.pix.green = snn_pkg::pix_t'((acc_g + cnt / 2) / cnt);
      r.pix.blue  = snn_pkg::pix_t'((acc_b + cnt / 2) / cnt);
      r.pix.alpha = snn_pkg::pix_t'((acc_a + cnt / 2) / cnt);
      r.frame_end = (c == wd - 1 && rw == ht - 1);
      made = 1'b1;
    end
    if (c + 1 >= wd) begin
      col_cnt = 0;
      row_cnt = (rw + 1 >= ht) ? 0 : rw + 1;
    end else begin
      col_cnt = c + 1;
    end
    return made;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(99);
    if (no_gaps || sel < 60) return 0;
    if (sel < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // input side: take accepted items, predict, and track registers
  always @(posedge clk_i) begin
    filt_res_t r;
    in_fired <= pix.valid && pix.ready;
    if (!rst_ni) begin
      radius_q <= snn_pkg::RADIUS_RST;
      pairs_q  <= snn_pkg::PAIRS_RST;
      width_q  <= snn_pkg::WIDTH_RST;
      height_q <= snn_pkg::HEIGHT_RST;
      col_cnt = 0;
      row_cnt = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        if (filter_pixel({pix.in_red, pix.in_green, pix.in_blue, pix.in_alpha}, r))
          expected_res.push_back(r);
        void'(pending_pix.pop_front());
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          snn_pkg::CFG_RADIUS: radius_q <= cfg.data[3:0];
          snn_pkg::CFG_PAIRS:  pairs_q  <= cfg.data[1:0];
          snn_pkg::CFG_WIDTH:  width_q  <= cfg.data[10:0];
          snn_pkg::CFG_HEIGHT: height_q <= cfg.data[15:0];
          default: ;
        endcase
      end
    end
  end

  // output side: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    filt_res_t got, want;
    if (rst_ni && res.valid && res.ready) begin
      got = {res.out_red, res.out_green, res.out_blue, res.out_alpha, res.frame_end};
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (got.pix.red !== want.pix.red)
          $display("%0t: red exp %h got %h", $realtime, want.pix.red, got.pix.red);
        if (got.pix.green !== want.pix.green)
          $display("%0t: green exp %h got %h", $realtime, want.pix.green, got.pix.green);
        if (got.pix.blue !== want.pix.blue)
          $display("%0t: blue exp %h got %h", $realtime, want.pix.blue, got.pix.blue);
        if (got.pix.alpha !== want.pix.alpha)
          $display("%0t: alpha exp %h got %h", $realtime, want.pix.alpha, got.pix.alpha);
        if (got.frame_end !== want.frame_end)
          $display("%0t: frame_end exp %b got %b", $realtime, want.frame_end, got.frame_end);
        if (got !== want) errors++;
      end
    end
  end

  // pixel driver, fed from the pending queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix.valid    <= 1'b0;
      pix.in_red   <= '0;
      pix.in_green <= '0;
      pix.in_blue  <= '0;
      pix.in_alpha <= '0;
      in_gap       <= 0;
    end else if (pix.valid && !in_fired) begin
      pix.valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      pix.valid <= 1'b0;
    end else if (pending_pix.size() > 0) begin
      pix.valid    <= 1'b1;
      pix.in_red   <= pending_pix[0].red;
      pix.in_green <= pending_pix[0].green;
      pix.in_blue  <= pending_pix[0].blue;
      pix.in_alpha <= pending_pix[0].alpha;
      in_gap       <= pick_gap();
    end else begin
      pix.valid <= 1'b0;
    end
  end

  // one long receiver hold-off, counted in cycles
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= 3000;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      out_gap   <= 0;
    end else if (hold_cnt > 0) begin
      res.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if (res.valid) out_gap <= pick_gap();
    end
  end

  task automatic push_rgba(int r, int g, int b, int a);
    rgba_t p;
    p.red = snn_pkg::pix_t'(r);
    p.green = snn_pkg::pix_t'(g);
    p.blue = snn_pkg::pix_t'(b);
    p.alpha = snn_pkg::pix_t'(a);
    pending_pix.push_back(p);
  endtask

  // one frame of random content: full range, clustered or flat
  task automatic push_frame(int n_items);
    int    style, base, i;
    rgba_t p;
    style = $urandom_range(2);
    base  = $urandom_range(65535);
    for (i = 0; i < n_items; i++) begin
      if (style == 0) begin
        p = {$urandom, $urandom};
      end else if (style == 1) begin
        p.red   = snn_pkg::pix_t'(base + $urandom_range(6));
        p.green = snn_pkg::pix_t'(base + $urandom_range(6));
        p.blue  = snn_pkg::pix_t'(base + $urandom_range(6));
        p.alpha = snn_pkg::pix_t'($urandom);
      end else begin
        p = {4{snn_pkg::pix_t'(base)}};
        if ($urandom_range(3) == 0) p.alpha = snn_pkg::pix_t'($urandom);
      end
      pending_pix.push_back(p);
    end
  endtask

  task automatic wait_idle();
    while (pending_pix.size() > 0 || pix.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(snn_pkg::cfg_idx_e idx, snn_pkg::cfg_data_t val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_mode(int rad, int prs, int wd, int ht);
    wait_idle();
    write_reg(snn_pkg::CFG_RADIUS, snn_pkg::cfg_data_t'(rad));
    write_reg(snn_pkg::CFG_PAIRS, snn_pkg::cfg_data_t'(prs));
    write_reg(snn_pkg::CFG_WIDTH, snn_pkg::cfg_data_t'(wd));
    write_reg(snn_pkg::CFG_HEIGHT, snn_pkg::cfg_data_t'(ht));
  endtask

  // stimulus
  initial begin
    int sent, rad, prs, wd, ht, k;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    cfg.valid = 1'b0; cfg.index = snn_pkg::CFG_RADIUS; cfg.data = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes around a mid grey centre, pairs with a tie at the corners
    set_mode(1, snn_pkg::PAIRS_MODE, 3, 3);
    push_rgba(0, 0, 0, 0);
    push_rgba(65535, 65535, 65535, 65535);
    push_rgba(32768, 32768, 32768, 0);
    push_rgba(0, 65535, 0, 65535);
    push_rgba(32768, 32768, 32768, 65535);
    push_rgba(65535, 0, 65535, 0);
    push_rgba(32768, 32768, 32768, 12345);
    push_rgba(1, 1, 1, 1);
    push_rgba(65535, 65535, 65535, 0);
    // flat frame in quadruple mode via a pairs value of zero: all ties
    set_mode(1, 0, 3, 3);
    for (k = 0; k < 9; k++) push_rgba(4660, 4660, 4660, k * 7000);
    // zero radius passes pixels through
    set_mode(0, 3, 4, 3);
    push_frame(12);
    // radius above the maximum saturates, full quadruple window
    set_mode(15, 2, 17, 17);
    push_frame(289);
    // zero width and height act as one: frame too small, no output
    set_mode(2, 1, 0, 0);
    push_frame(3);
    // too small frame with a non-trivial window
    set_mode(3, 2, 6, 9);
    push_frame(54);

    // random settings, whole frames, one long receiver hold-off early on
    sent = 0;
    while (sent < 550) begin
      rad = $urandom_range(4, 1);
      prs = $urandom_range(3);
      wd  = $urandom_range(12, 2 * rad + 1);
      ht  = $urandom_range(10, 2 * rad + 1);
      set_mode(rad, prs, wd, ht);
      if (sent == 0) hold_req = 1'b1;
      no_gaps = ($urandom_range(4) == 0);
      for (k = $urandom_range(3, 1); k > 0; k--) begin
        push_frame(wd * ht);
        sent += wd * ht;
      end
    end

    // tallest frame, only its first rows
    set_mode(1, 2, 5, 65535);
    push_frame(60);
    wait_idle();

    if (errors == 0 && expected_res.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
